### sv/pssu_pkg.sv
// Package for the parameter store with SGD update.
// Holds payload structs, controller states and status codes; no dependencies.
package pssu_pkg;

    typedef struct packed {
        logic        action;
        logic [63:0] key;
        logic [5:0]  element_index;
        logic signed [31:0] value;
        logic        last_element;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_key;
        logic [5:0]  out_index;
        logic signed [31:0] weight;
        logic        found;
        logic [1:0]  status;
        logic        last_result;
    } t_out_item;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_RD, S_RDWAIT, S_MUL, S_WR, S_PULL, S_PULLWAIT, S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic search_clr;
        logic search_step;
        logic push_decide;
        logic rd;
        logic mul;
        logic wr_sgd;
        logic pull_rd;
        logic emit;
        logic emit_pull;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic is_pull;
        logic do_sgd;
        logic pull_empty;
        logic pull_last;
    } t_stat;

endpackage

### sv/parameter_store_sgd_update.sv
// Parameter store with SGD update; depends on pssu_pkg, pssu_ctrl and pssu_datapath.
// Every item scans all ENTRIES slots, then decides. A push strobes one result, after a read,
// a multiply and a write-back when it makes an SGD update; a pull strobes one result per
// stored weight, or a single one when the key is not found or holds no weights.
// One item at a time: the next transfer can come at the edge ending the last result strobe.
// Results cannot be stalled. Sync active-low reset clears valid bits and fill state, rate 3277.
module parameter_store_sgd_update #(
    parameter int ENTRIES    = 256,
    parameter int VECTOR_LEN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pssu_pkg::t_in_item  i_item,
    output pssu_pkg::t_out_item o_result,
    output logic                o_result_strobe,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import pssu_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [15:0] r_rate;

    // learning rate register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rate <= 16'd3277;
        else if (i_cfg_valid) r_rate <= i_cfg_data;
    end

    pssu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    pssu_datapath #(.ENTRIES(ENTRIES), .VECTOR_LEN(VECTOR_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(i_item),
        .i_rate(r_rate), .o_stat(stat), .o_result(o_result),
        .o_result_strobe(o_result_strobe)
    );
endmodule

### sv/pssu_ctrl.sv
// Controller state machine of the parameter store.
// Depends on pssu_pkg.
module pssu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pssu_pkg::t_stat i_stat,
    output pssu_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import pssu_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_start) n_state = S_SEARCH;
            S_SEARCH:   if (i_stat.search_done) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.is_pull) n_state = i_stat.pull_empty ? S_EMIT : S_PULL;
                else if (i_stat.do_sgd) n_state = S_RD;
                else n_state = S_EMIT;
            end
            S_RD:       n_state = S_RDWAIT;
            S_RDWAIT:   n_state = S_MUL;
            S_MUL:      n_state = S_WR;
            S_WR:       n_state = S_EMIT;
            S_PULL:     n_state = S_PULLWAIT;
            S_PULLWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.is_pull && !i_stat.pull_empty && !i_stat.pull_last)
                    n_state = S_PULL;
                else n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   begin o_cmd.load = i_start; o_cmd.search_clr = i_start; end
            S_SEARCH: o_cmd.search_step = 1'b1;
            S_DECIDE: o_cmd.push_decide = !i_stat.is_pull;
            S_RD:     o_cmd.rd = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_WR:     o_cmd.wr_sgd = 1'b1;
            S_PULL:   o_cmd.pull_rd = 1'b1;
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_pull = i_stat.is_pull && !i_stat.pull_empty;
            end
            default: ;
        endcase
    end

    // search advances only while busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search_step |-> o_busy) else $error("search outside item");
    // an emit always follows with either idle or another pull read
    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> (r_state == S_IDLE || r_state == S_PULL))
        else $error("bad state after emit");
    // start is taken only when idle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SEARCH)) else $error("start lost");
endmodule

### sv/pssu_datapath.sv
// Datapath: key table search, weight memory, SGD multiply and result register.
// Depends on pssu_pkg.
module pssu_datapath #(
    parameter int ENTRIES    = 256,
    parameter int VECTOR_LEN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pssu_pkg::t_cmd      i_cmd,
    input  pssu_pkg::t_in_item  i_item,
    input  logic [15:0]         i_rate,
    output pssu_pkg::t_stat     o_stat,
    output pssu_pkg::t_out_item o_result,
    output logic                o_result_strobe
);
    import pssu_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int AW = SW + VW;
    localparam int LW = $clog2(VECTOR_LEN + 1);

    // tables; weight rows are padded to a power of two so {slot, index} addresses them
    logic [63:0]   r_keys [ENTRIES];
    logic [LW-1:0] r_len  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic signed [31:0] r_wmem [ENTRIES*(2**VW)];

    // item and search state
    t_in_item      r_item;
    logic [SW:0]   r_cnt;
    logic          r_hit, r_free_ok;
    logic [SW-1:0] r_hit_slot, r_free_slot;
    logic [63:0]   r_key_rd;
    logic [LW-1:0] r_len_rd;
    logic          r_valid_rd, r_rd_ok;
    logic [SW-1:0] r_rd_slot;
    logic          r_fill_act;
    logic [SW-1:0] r_fill_slot;
    logic [63:0]   r_fill_key;
    logic [LW-1:0] r_plen;
    logic [VW-1:0] r_pidx;
    logic signed [31:0] r_wrd, r_wq;
    logic signed [48:0] r_prod;
    logic          r_do_sgd;
    t_out_item     r_pres, n_pres;
    t_out_item     r_res, n_res;
    logic          r_strobe;

    logic [SW-1:0] rd_slot;
    assign rd_slot = r_cnt[SW-1:0];

    // search: one table entry read per cycle, compared the next cycle
    always_ff @(posedge i_clk) begin
        r_key_rd   <= r_keys[rd_slot];
        r_len_rd   <= r_len[rd_slot];
        r_valid_rd <= r_valid[rd_slot];
        r_rd_slot  <= rd_slot;
        if (i_cmd.load) r_item <= i_item;
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_cmd.search_clr) begin
            r_cnt <= '0; r_hit <= 1'b0; r_free_ok <= 1'b0; r_rd_ok <= 1'b0;
        end else if (i_cmd.search_step) begin
            if (r_cnt < (SW+1)'(ENTRIES)) r_cnt <= r_cnt + 1'b1;
            r_rd_ok <= (r_cnt < (SW+1)'(ENTRIES));
            if (r_rd_ok) begin
                if (r_valid_rd && r_key_rd == r_item.key && !r_hit) begin
                    r_hit <= 1'b1; r_hit_slot <= r_rd_slot; r_plen <= r_len_rd;
                end
                if (!r_valid_rd && !r_free_ok) begin
                    r_free_ok <= 1'b1; r_free_slot <= r_rd_slot;
                end
            end
        end
    end

    assign o_stat.search_done = !r_rd_ok && (r_cnt == (SW+1)'(ENTRIES));
    assign o_stat.is_pull     = (r_item.action == ACT_PULL);
    assign o_stat.pull_empty  = !r_hit || (r_plen == '0);
    assign o_stat.pull_last   = ({1'b0, r_pidx} + 1'b1) == (VW+1)'(r_plen);

    // push decision; a filling key always hits its own slot, so r_plen is its length
    logic fill_cont;
    logic idx_ok;
    assign fill_cont = r_fill_act && (r_fill_key == r_item.key);
    assign idx_ok    = ({1'b0, r_item.element_index} < 7'(VECTOR_LEN));
    logic [VW-1:0] eidx;
    assign eidx = r_item.element_index[VW-1:0];
    logic len_ok;
    assign len_ok = (7'(r_plen) > {1'b0, r_item.element_index}) && idx_ok;
    assign o_stat.do_sgd = !fill_cont && r_hit && len_ok;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [31:0] wr_data;
    logic [AW-1:0] rd_addr;

    // SGD arithmetic: round half up, saturating subtract
    logic signed [49:0] q_round;
    logic signed [33:0] diff;
    logic signed [31:0] sat_q;
    assign q_round = (50'(r_prod) + 50'sd32768) >>> 16;
    assign diff = 34'(r_wrd) - 34'(q_round);

    always_comb begin
        if (diff > 34'sd2147483647) sat_q = 32'sh7fffffff;
        else if (diff < -34'sd2147483648) sat_q = 32'sh80000000;
        else sat_q = 32'(diff);
    end

    // table and fill state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_fill_act <= 1'b0; r_fill_slot <= '0; r_fill_key <= '0;
        end else if (i_cmd.push_decide) begin
            if (fill_cont) begin
                if (idx_ok) begin
                    if (r_item.last_element) begin
                        r_len[r_fill_slot] <= LW'({1'b0, r_item.element_index} + 7'd1);
                        r_fill_act <= 1'b0;
                    end else if (({1'b0, r_item.element_index} + 7'd1) > 7'(r_plen)) begin
                        r_len[r_fill_slot] <= LW'({1'b0, r_item.element_index} + 7'd1);
                    end
                end
            end else if (!r_hit && r_free_ok && idx_ok) begin
                r_valid[r_free_slot] <= 1'b1;
                r_keys[r_free_slot]  <= r_item.key;
                r_len[r_free_slot]   <= LW'({1'b0, r_item.element_index} + 7'd1);
                r_fill_act <= !r_item.last_element;
                if (!r_item.last_element) begin
                    r_fill_slot <= r_free_slot;
                    r_fill_key  <= r_item.key;
                end
            end else begin
                // any other push ends an open fill
                r_fill_act <= 1'b0;
            end
        end
    end

    // result of a push, taken at the decision cycle
    always_comb begin
        n_pres = '0;
        n_pres.out_key     = r_item.key;
        n_pres.out_index   = r_item.element_index;
        n_pres.last_result = 1'b1;
        if (fill_cont) begin
            n_pres.found = 1'b1;
            if (idx_ok) n_pres.weight = r_item.value;
            else n_pres.status = ST_IDX;
        end else if (r_hit) begin
            n_pres.found = 1'b1;
            if (!len_ok) n_pres.status = ST_IDX;
        end else if (!r_free_ok) begin
            n_pres.status = ST_FULL;
        end else if (!idx_ok) begin
            n_pres.status = ST_IDX;
        end else begin
            n_pres.weight = r_item.value;
        end
    end

    // weight memory port selection
    always_comb begin
        wr_en = 1'b0; wr_addr = '0; wr_data = r_item.value;
        if (i_cmd.push_decide && idx_ok) begin
            if (fill_cont) begin
                wr_en = 1'b1; wr_addr = {r_fill_slot, eidx};
            end else if (!r_hit && r_free_ok) begin
                wr_en = 1'b1; wr_addr = {r_free_slot, eidx};
            end
        end else if (i_cmd.wr_sgd) begin
            wr_en = 1'b1; wr_addr = {r_hit_slot, eidx}; wr_data = sat_q;
        end
        rd_addr = i_cmd.pull_rd ? {r_hit_slot, r_pidx} : {r_hit_slot, eidx};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_wmem[wr_addr] <= wr_data;
        if (i_cmd.rd || i_cmd.pull_rd) r_wrd <= r_wmem[rd_addr];
    end

    // multiply, then round and saturate
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= r_item.value * $signed({1'b0, i_rate});
        if (i_cmd.wr_sgd) r_wq <= sat_q;
        else if (i_cmd.push_decide) r_wq <= '0;
        if (i_cmd.push_decide) r_pres <= n_pres;
    end

    // next result: a pull weight or the decided push result
    always_comb begin
        n_res = r_pres;
        if (r_item.action == ACT_PULL) begin
            n_res = '0;
            n_res.out_key     = r_item.key;
            n_res.last_result = 1'b1;
            n_res.found       = r_hit;
            if (!o_stat.pull_empty) begin
                n_res.out_index   = 6'(r_pidx);
                n_res.weight      = r_wrd;
                n_res.last_result = o_stat.pull_last;
            end
        end else if (r_do_sgd) begin
            n_res.weight = r_wq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0; r_do_sgd <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.push_decide) r_do_sgd <= o_stat.do_sgd;
            else if (i_cmd.emit && r_item.action == ACT_PUSH) r_do_sgd <= 1'b0;
            if (i_cmd.search_clr) r_pidx <= '0;
            else if (i_cmd.emit_pull) r_pidx <= r_pidx + 1'b1;
            if (i_cmd.emit) r_res <= n_res;
        end
    end

    assign o_result = r_res;
    assign o_result_strobe = r_strobe;

    // a new entry is only taken from a free slot
    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_decide && !fill_cont && !r_hit && r_free_ok && idx_ok)
        |-> !r_valid[r_free_slot]) else $error("allocated a used slot");
    // a weight update only targets a hit slot
    a_sgd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_sgd |-> r_hit) else $error("update without hit");
    // strobe follows an emit command
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_strobe) else $error("result lost");
endmodule

### sim/parameter_store_sgd_update_test.sv
// Self-checking testbench for parameter_store_sgd_update: push/pull items are
// generated, predicted and compared field by field. Depends on pssu_pkg and the RTL.
module parameter_store_sgd_update_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pssu_pkg::*;

    localparam int NSLOT = 256;
    localparam int VLEN  = 64;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    t_out_item o_result;
    logic      o_result_strobe;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    parameter_store_sgd_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result(o_result), .o_result_strobe(o_result_strobe),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // pending items and expected results
    t_in_item  pend_q[$];
    t_out_item weight_q[$];
    int n_sent = 0, n_acc = 0, n_res = 0, n_pull = 0, n_err = 0;

    // predicted table
    logic [63:0] tb_key[NSLOT];
    bit          tb_valid[NSLOT];
    int          tb_len[NSLOT];
    logic signed [31:0] tb_w[NSLOT][VLEN];
    bit          tb_fill = 0;
    int          tb_fslot = 0;
    logic [63:0] tb_fkey = '0;
    logic [15:0] tb_rate = 16'd3277;

    // generator-side tracker, keeps fills contiguous so no unwritten weight is read
    int          gen_len[bit [63:0]];
    logic [63:0] known_keys[$];
    bit          gen_fill = 0;
    logic [63:0] gen_fkey = '0;

    function automatic int lookup(logic [63:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (tb_valid[i] && tb_key[i] == k) return i;
        return -1;
    endfunction

    function automatic logic signed [31:0] sgd_step(logic signed [31:0] w,
                                                    logic signed [31:0] g);
        longint p;
        longint r;
        p = (longint'(g) * longint'({16'd0, tb_rate}) + 32768) >>> 16;
        r = longint'(w) - p;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_out_item mk_res(logic [63:0] k, logic [5:0] ix,
                                         logic signed [31:0] w, logic f,
                                         logic [1:0] st, logic lst);
        t_out_item r;
        r.out_key = k; r.out_index = ix; r.weight = w;
        r.found = f; r.status = st; r.last_result = lst;
        return r;
    endfunction

    // expected results of one accepted item
    task automatic predict_weights(t_in_item it);
        int s, n, a;
        a = it.element_index;
        if (it.action == ACT_PULL) begin
            n_pull++;
            s = lookup(it.key);
            if (s < 0) begin
                weight_q.push_back(mk_res(it.key, 6'd0, 32'sd0, 1'b0, ST_OK, 1'b1));
            end else begin
                n = tb_len[s] > VLEN ? VLEN : tb_len[s];
                if (n == 0)
                    weight_q.push_back(mk_res(it.key, 6'd0, 32'sd0, 1'b1, ST_OK, 1'b1));
                for (int i = 0; i < n; i++)
                    weight_q.push_back(mk_res(it.key, i[5:0], tb_w[s][i], 1'b1, ST_OK,
                                              i + 1 == n));
            end
            return;
        end
        if (tb_fill && tb_fkey != it.key) tb_fill = 0;
        if (tb_fill) begin
            tb_w[tb_fslot][a] = it.value;
            if (it.last_element) begin
                tb_len[tb_fslot] = a + 1;
                tb_fill = 0;
            end else if (a + 1 > tb_len[tb_fslot]) begin
                tb_len[tb_fslot] = a + 1;
            end
            weight_q.push_back(mk_res(it.key, it.element_index, it.value, 1'b1, ST_OK, 1'b1));
            return;
        end
        s = lookup(it.key);
        if (s >= 0) begin
            if (a >= tb_len[s]) begin
                weight_q.push_back(mk_res(it.key, it.element_index, 32'sd0, 1'b1, ST_IDX, 1'b1));
            end else begin
                tb_w[s][a] = sgd_step(tb_w[s][a], it.value);
                weight_q.push_back(mk_res(it.key, it.element_index, tb_w[s][a], 1'b1, ST_OK,
                                          1'b1));
            end
            return;
        end
        s = -1;
        for (int i = 0; i < NSLOT && s < 0; i++)
            if (!tb_valid[i]) s = i;
        if (s < 0) begin
            weight_q.push_back(mk_res(it.key, it.element_index, 32'sd0, 1'b0, ST_FULL, 1'b1));
            return;
        end
        tb_valid[s] = 1; tb_key[s] = it.key; tb_len[s] = a + 1;
        tb_w[s][a] = it.value;
        if (!it.last_element) begin
            tb_fill = 1; tb_fslot = s; tb_fkey = it.key;
        end
        weight_q.push_back(mk_res(it.key, it.element_index, it.value, 1'b0, ST_OK, 1'b1));
    endtask

    // queue an item and track what the table will hold
    task automatic send(logic act, logic [63:0] k, int ix, logic [31:0] v, logic lst);
        t_in_item it;
        it.action = act; it.key = k; it.element_index = ix[5:0];
        it.value = v; it.last_element = lst;
        pend_q.push_back(it);
        n_sent++;
        if (act == ACT_PULL) return;
        if (gen_fill && gen_fkey != k) gen_fill = 0;
        if (gen_fill) begin
            if (lst) begin
                gen_len[k] = ix + 1;
                gen_fill = 0;
            end else if (ix + 1 > gen_len[k]) begin
                gen_len[k] = ix + 1;
            end
        end else if (!gen_len.exists(k) && known_keys.size() < NSLOT) begin
            gen_len[k] = ix + 1;
            known_keys.push_back(k);
            if (!lst) begin
                gen_fill = 1; gen_fkey = k;
            end
        end
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rnd_key();
        return {$urandom, $urandom};
    endfunction

    // one random phase of fills, updates (some beyond the stored length) and pulls
    task automatic random_phase(int count);
        int base, len, ix;
        logic [63:0] k;
        base = n_sent;
        while (n_sent - base < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    k = rnd_key();
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++) begin
                        send(ACT_PUSH, k, i, rnd_val(),
                             (i == len - 1) && ($urandom_range(0, 4) != 0));
                        if ($urandom_range(0, 7) == 0) send(ACT_PULL, k, 0, $urandom, 1'b0);
                    end
                end
                4, 5, 6: if (known_keys.size() > 0) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    len = gen_len[k];
                    if (gen_fill && gen_fkey == k)
                        ix = $urandom_range(0, len > VLEN - 1 ? VLEN - 1 : len);
                    else if ($urandom_range(0, 3) == 0)
                        ix = $urandom_range(0, VLEN - 1);
                    else
                        ix = $urandom_range(0, len - 1);
                    send(ACT_PUSH, k, ix, rnd_val(), 1'($urandom_range(0, 1)));
                end
                7, 8: if (known_keys.size() > 0) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    send(ACT_PULL, k, $urandom_range(0, 63), $urandom,
                         1'($urandom_range(0, 1)));
                end
                default: send(ACT_PULL, rnd_key(), $urandom_range(0, 63), $urandom,
                              1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || n_acc != n_sent || weight_q.size() != 0 || start || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        tb_rate = v;
        i_cfg_valid <= 1'b0;
    endtask

    // driver: bursts of transfers with random gaps
    int burst_left = 3, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_weights(i_item);
                n_acc++;
            end
            if (start && busy) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pend_q.size() > 0) begin
                i_item <= pend_q.pop_front();
                start  <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_result_strobe) begin
            n_res++;
            if (weight_q.size() == 0) begin
                $error("unexpected result key=%h index=%0d", o_result.out_key,
                       o_result.out_index);
                n_err++;
            end else begin
                e = weight_q.pop_front();
                if (o_result.out_key !== e.out_key) begin
                    $error("out_key expected %h actual %h", e.out_key, o_result.out_key);
                    n_err++;
                end
                if (o_result.out_index !== e.out_index) begin
                    $error("out_index expected %0d actual %0d", e.out_index, o_result.out_index);
                    n_err++;
                end
                if (o_result.weight !== e.weight) begin
                    $error("weight expected %0d actual %0d", e.weight, o_result.weight);
                    n_err++;
                end
                if (o_result.found !== e.found) begin
                    $error("found expected %0d actual %0d", e.found, o_result.found);
                    n_err++;
                end
                if (o_result.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_result.status);
                    n_err++;
                end
                if (o_result.last_result !== e.last_result) begin
                    $error("last_result expected %0d actual %0d", e.last_result,
                           o_result.last_result);
                    n_err++;
                end
            end
        end
    end

    // run limit
    initial begin
        #8ms;
        $display("parameter_store_sgd_update_test: FAIL");
        $finish;
    end

    initial begin
        logic [63:0] kz, k1;
        kz = 64'd0;
        k1 = {64{1'b1}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill, pull mid-fill, saturation, index beyond length,
        // interrupted fill, not-found pull; default rate
        send(ACT_PULL, k1, 0, 32'h0, 1'b0);
        send(ACT_PUSH, kz, 0, 32'h7FFF_FFFF, 1'b0);
        send(ACT_PUSH, kz, 1, 32'h8000_0000, 1'b0);
        send(ACT_PULL, kz, 0, 32'h0, 1'b0);
        send(ACT_PUSH, kz, 2, 32'h0001_0000, 1'b1);
        send(ACT_PULL, kz, 63, 32'hFFFF_FFFF, 1'b1);
        send(ACT_PUSH, kz, 0, 32'h8000_0000, 1'b0);
        send(ACT_PUSH, kz, 1, 32'h7FFF_FFFF, 1'b1);
        send(ACT_PUSH, kz, 2, 32'hFFFF_FFFF, 1'b0);
        send(ACT_PUSH, kz, 63, 32'h1234_5678, 1'b1);
        send(ACT_PUSH, kz, 3, 32'h1, 1'b0);
        send(ACT_PUSH, k1, 0, 32'hFFFF_8000, 1'b0);
        send(ACT_PUSH, k1, 1, 32'h0000_8000, 1'b0);
        send(ACT_PUSH, kz, 2, 32'h0000_8000, 1'b0);
        send(ACT_PUSH, k1, 2, 32'h5, 1'b0);
        send(ACT_PULL, k1, 0, 32'h0, 1'b0);
        send(ACT_PUSH, k1, 0, 32'h0000_8000, 1'b0);
        send(ACT_PULL, kz, 0, 32'h0, 1'b0);
        wait_idle();

        write_rate(16'hFFFF);
        send(ACT_PUSH, kz, 0, 32'h8000_0000, 1'b0);
        send(ACT_PUSH, kz, 1, 32'h7FFF_FFFF, 1'b0);
        random_phase(26);
        wait_idle();

        write_rate(16'h0000);
        send(ACT_PUSH, kz, 2, 32'h7FFF_FFFF, 1'b0);
        random_phase(26);
        wait_idle();

        write_rate(16'($urandom_range(1, 65534)));
        random_phase(26);
        wait_idle();

        // back to the default rate for a short closing phase
        write_rate(16'd3277);
        random_phase(10);
        wait_idle();
        repeat (400) @(posedge i_clk);

        if (weight_q.size() != 0) begin
            $error("%0d expected results never arrived", weight_q.size());
            n_err++;
        end
        $display("Covered %0d items (%0d pulls), %0d results, fills, updates and drops",
                 n_acc, n_pull, n_res);
        $display("under the default, maximum, zero and a random learning rate.");
        if (n_err == 0) begin
            $display("parameter_store_sgd_update_test: PASS");
        end else begin
            $display("parameter_store_sgd_update_test: FAIL");
        end
        $finish;
    end

endmodule
